>>> design/rpi_pkg.sv
// ----------------------------------------------------------------------------
// rpi_pkg: shared types and constants of the ray/plane intersection block
// command codes of the input stream, the multiply schedule bounds and the
// command/status bundles between controller and datapath
// ----------------------------------------------------------------------------
package rpi_pkg;

    // kind of input request (carried in tuser)
    localparam logic [2:0] CMD_V2  = 3'd2;   // codes up to this one load a vertex
    localparam logic [2:0] CMD_ORG = 3'd3;   // load ray origin
    localparam logic [2:0] CMD_DIR = 3'd4;   // ray direction, compute a point

    // multiply schedule: steps 0..17 build den and num, 18..20 the point
    localparam int unsigned STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_NUM_LAST = 5'd17;
    localparam logic [STEP_W-1:0] STEP_PT_FIRST = 5'd18;
    localparam logic [STEP_W-1:0] STEP_PT_LAST  = 5'd20;

    typedef struct packed {
        logic              vtx_we;
        logic              org_we;
        logic              dir_we;
        logic              diff_en;
        logic              mul_en;
        logic [STEP_W-1:0] step;
        logic              div_start;
        logic              out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_sts;

endpackage

>>> design/rpi_div.sv
// ----------------------------------------------------------------------------
// rpi_div: iterative quotient unit
// radix-2 restoring division of |num| * 2^FB by |den|, one quotient bit per
// cycle, with an up-front range check and saturation of the signed result
// ----------------------------------------------------------------------------
module rpi_div #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16,
    parameter int ACC_WIDTH     = 50
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [ACC_WIDTH-1:0]   i_num,
    input  logic signed [ACC_WIDTH-1:0]   i_den,
    output logic                          o_done,
    output logic                          o_zero,
    output logic                          o_sat,
    output logic signed [COORD_WIDTH-1:0] o_q
);
    import rpi_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int NW   = ACC_WIDTH + FRACTION_BITS;
    localparam int CMPW = ACC_WIDTH + COORD_WIDTH + FRACTION_BITS;
    localparam int CNTW = $clog2(COORD_WIDTH);
    localparam logic [CW-1:0] Q_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] Q_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_CHK  = 4'b0010,
        D_RUN  = 4'b0100,
        D_FIN  = 4'b1000
    } t_dstate;

    t_dstate                r_state, n_state;
    logic [CNTW-1:0]        r_cnt;
    logic [ACC_WIDTH-1:0]   r_n, r_d, r_rem;
    logic [CW-1:0]          r_nsh, r_q;
    logic                   r_neg, r_zero, r_ovf;

    logic [NW-1:0]          w_nfull;
    logic                   w_ovf;
    logic [ACC_WIDTH:0]     w_trial;
    logic                   w_ge;
    logic [CW-1:0]          w_lim;
    logic                   w_over;

    assign w_nfull = {r_n, {FRACTION_BITS{1'b0}}};
    // quotient fits in CW bits only when n * 2^FB < d * 2^CW
    assign w_ovf   = (CMPW'(r_n) << FRACTION_BITS) >= (CMPW'(r_d) << COORD_WIDTH);
    assign w_trial = {r_rem, r_nsh[CW-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};
    assign w_lim   = r_neg ? Q_MIN : Q_MAX;
    assign w_over  = r_ovf || (r_q > w_lim);

    assign o_done = (r_state == D_FIN);
    assign o_zero = r_zero;
    assign o_sat  = w_over;
    assign o_q    = w_over ? (r_neg ? Q_MIN : Q_MAX) : (r_neg ? (~r_q + 1'b1) : r_q);

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE: if (i_start) n_state = D_CHK;
            D_CHK:  n_state = (r_zero || w_ovf) ? D_FIN : D_RUN;
            D_RUN:  if (r_cnt == CNTW'(COORD_WIDTH - 1)) n_state = D_FIN;
            D_FIN:  n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_n    <= i_num[ACC_WIDTH-1] ? (~i_num + 1'b1) : i_num;
                    r_d    <= i_den[ACC_WIDTH-1] ? (~i_den + 1'b1) : i_den;
                    r_neg  <= i_num[ACC_WIDTH-1] ^ i_den[ACC_WIDTH-1];
                    r_zero <= (i_den == '0);
                end
            end
            D_CHK: begin
                r_ovf <= w_ovf;
                r_rem <= ACC_WIDTH'(w_nfull >> COORD_WIDTH);
                r_nsh <= w_nfull[CW-1:0];
                r_q   <= '0;
                r_cnt <= '0;
            end
            D_RUN: begin
                r_rem <= w_ge ? ACC_WIDTH'(w_trial - {1'b0, r_d}) : w_trial[ACC_WIDTH-1:0];
                r_q   <= {r_q[CW-2:0], w_ge};
                r_nsh <= {r_nsh[CW-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> design/rpi_dp.sv
// ----------------------------------------------------------------------------
// rpi_dp: datapath of the ray/plane intersection block
// vertex and origin store, edge differences, one shared multiplier with an
// accumulator, the quotient unit and the output register
// ----------------------------------------------------------------------------
module rpi_dp #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rpi_pkg::t_dp_cmd   i_cmd,
    output rpi_pkg::t_dp_sts   o_sts,
    input  logic [2:0]         i_in_cmd,
    input  logic [31:0]        i_in_x,
    input  logic [31:0]        i_in_y,
    input  logic [31:0]        i_in_z,
    output logic [31:0]        o_point_x,
    output logic [31:0]        o_point_y,
    output logic [31:0]        o_point_z,
    output logic               o_parallel,
    output logic               o_saturated
);
    import rpi_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int PW   = 2 * COORD_WIDTH;
    localparam int MQW  = PW - FRACTION_BITS;
    localparam int ACCW = (MQW + 2 > CW + 2) ? MQW + 2 : CW + 2;
    localparam logic [CW-1:0] V_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] V_MIN = {1'b1, {(CW-1){1'b0}}};

    // clamp to the coordinate range, flag in the top bit
    function automatic logic [CW:0] f_sat(input logic signed [ACCW-1:0] v);
        logic [ACCW-CW:0] hi;
        hi = v[ACCW-1:CW-1];
        if ((&hi) || !(|hi)) begin
            return {1'b0, v[CW-1:0]};
        end
        return {1'b1, v[ACCW-1] ? V_MIN : V_MAX};
    endfunction

    logic signed [CW-1:0]   r_vtx [3][3];
    logic signed [CW-1:0]   r_org [3];
    logic signed [CW-1:0]   r_dir [3];
    logic signed [CW-1:0]   r_e1 [3];
    logic signed [CW-1:0]   r_e2 [3];
    logic signed [CW-1:0]   r_s  [3];
    logic signed [CW-1:0]   r_cr [3];
    logic signed [CW-1:0]   r_pt [3];
    logic signed [CW-1:0]   r_t;
    logic signed [PW-1:0]   r_prod;
    logic signed [ACCW-1:0] r_acc, r_den, r_num;
    logic                   r_mvld;
    logic [STEP_W-1:0]      r_mstep;
    logic                   r_sf, r_par;
    logic signed [CW-1:0]   r_out_x, r_out_y, r_out_z;
    logic                   r_out_par, r_out_sf;

    logic signed [CW-1:0]   w_in [3];
    logic [CW:0]            w_e1 [3];
    logic [CW:0]            w_e2 [3];
    logic [CW:0]            w_s  [3];
    logic                   w_diff_sf;
    logic signed [CW-1:0]   w_op_a, w_op_b;
    logic signed [ACCW-1:0] w_prod_sh;
    logic [CW:0]            w_cross;
    logic signed [CW-1:0]   w_pt_org;
    logic [CW:0]            w_pt;
    logic [CW:0]            w_num_sat;
    logic                   w_div_done, w_div_zero, w_div_sat;
    logic signed [CW-1:0]   w_div_q;

    assign w_in[0] = i_in_x[CW-1:0];
    assign w_in[1] = i_in_y[CW-1:0];
    assign w_in[2] = i_in_z[CW-1:0];

    // edge vectors and origin offset, saturated
    always_comb begin
        w_diff_sf = 1'b0;
        for (int k = 0; k < 3; k++) begin
            w_e1[k] = f_sat(ACCW'(r_vtx[1][k]) - ACCW'(r_vtx[0][k]));
            w_e2[k] = f_sat(ACCW'(r_vtx[2][k]) - ACCW'(r_vtx[0][k]));
            w_s[k]  = f_sat(ACCW'(r_org[k]) - ACCW'(r_vtx[0][k]));
            w_diff_sf = w_diff_sf | w_e1[k][CW] | w_e2[k][CW] | w_s[k][CW];
        end
    end

    // operand selection per schedule step
    always_comb begin
        case (i_cmd.step)
            5'd0:  begin w_op_a = r_dir[1]; w_op_b = r_e2[2]; end
            5'd1:  begin w_op_a = r_dir[2]; w_op_b = r_e2[1]; end
            5'd2:  begin w_op_a = r_dir[2]; w_op_b = r_e2[0]; end
            5'd3:  begin w_op_a = r_dir[0]; w_op_b = r_e2[2]; end
            5'd4:  begin w_op_a = r_dir[0]; w_op_b = r_e2[1]; end
            5'd5:  begin w_op_a = r_dir[1]; w_op_b = r_e2[0]; end
            5'd6:  begin w_op_a = r_e1[0];  w_op_b = r_cr[0]; end
            5'd7:  begin w_op_a = r_e1[1];  w_op_b = r_cr[1]; end
            5'd8:  begin w_op_a = r_e1[2];  w_op_b = r_cr[2]; end
            5'd9:  begin w_op_a = r_s[1];   w_op_b = r_e1[2]; end
            5'd10: begin w_op_a = r_s[2];   w_op_b = r_e1[1]; end
            5'd11: begin w_op_a = r_s[2];   w_op_b = r_e1[0]; end
            5'd12: begin w_op_a = r_s[0];   w_op_b = r_e1[2]; end
            5'd13: begin w_op_a = r_s[0];   w_op_b = r_e1[1]; end
            5'd14: begin w_op_a = r_s[1];   w_op_b = r_e1[0]; end
            5'd15: begin w_op_a = r_e2[0];  w_op_b = r_cr[0]; end
            5'd16: begin w_op_a = r_e2[1];  w_op_b = r_cr[1]; end
            5'd17: begin w_op_a = r_e2[2];  w_op_b = r_cr[2]; end
            5'd18: begin w_op_a = r_t;      w_op_b = r_dir[0]; end
            5'd19: begin w_op_a = r_t;      w_op_b = r_dir[1]; end
            default: begin w_op_a = r_t;    w_op_b = r_dir[2]; end
        endcase
    end

    // floored product, then the action of the step that produced it
    assign w_prod_sh = ACCW'(r_prod >>> FRACTION_BITS);
    assign w_cross   = f_sat(r_acc - w_prod_sh);

    always_comb begin
        case (r_mstep)
            5'd18:   w_pt_org = r_org[0];
            5'd19:   w_pt_org = r_org[1];
            default: w_pt_org = r_org[2];
        endcase
    end
    assign w_pt      = f_sat(ACCW'(w_pt_org) + w_prod_sh);
    assign w_num_sat = f_sat(r_num);

    rpi_div #(
        .COORD_WIDTH   (COORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS),
        .ACC_WIDTH     (ACCW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_zero  (w_div_zero),
        .o_sat   (w_div_sat),
        .o_q     (w_div_q)
    );

    assign o_sts.div_done = w_div_done;

    // triangle and origin store, zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < 3; v++) begin
                for (int k = 0; k < 3; k++) begin
                    r_vtx[v][k] <= '0;
                end
                r_org[v] <= '0;
            end
        end else begin
            if (i_cmd.vtx_we) begin
                for (int k = 0; k < 3; k++) begin
                    r_vtx[i_in_cmd[1:0]][k] <= w_in[k];
                end
            end
            if (i_cmd.org_we) begin
                for (int k = 0; k < 3; k++) begin
                    r_org[k] <= w_in[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld <= 1'b0;
        end else begin
            r_mvld <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= w_op_a * w_op_b;
        r_mstep <= i_cmd.step;

        if (i_cmd.dir_we) begin
            for (int k = 0; k < 3; k++) begin
                r_dir[k] <= w_in[k];
            end
        end

        if (i_cmd.diff_en) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= w_e1[k][CW-1:0];
                r_e2[k] <= w_e2[k][CW-1:0];
                r_s[k]  <= w_s[k][CW-1:0];
            end
            r_sf <= w_diff_sf;
        end

        if (r_mvld) begin
            case (r_mstep)
                5'd0, 5'd2, 5'd4, 5'd6, 5'd9, 5'd11, 5'd13, 5'd15: begin
                    r_acc <= w_prod_sh;
                end
                5'd1, 5'd10: begin
                    r_cr[0] <= w_cross[CW-1:0];
                    r_sf    <= r_sf | w_cross[CW];
                end
                5'd3, 5'd12: begin
                    r_cr[1] <= w_cross[CW-1:0];
                    r_sf    <= r_sf | w_cross[CW];
                end
                5'd5, 5'd14: begin
                    r_cr[2] <= w_cross[CW-1:0];
                    r_sf    <= r_sf | w_cross[CW];
                end
                5'd7, 5'd16: r_acc <= r_acc + w_prod_sh;
                5'd8:        r_den <= r_acc + w_prod_sh;
                5'd17:       r_num <= r_acc + w_prod_sh;
                5'd18: begin
                    r_pt[0] <= w_pt[CW-1:0];
                    r_sf    <= r_sf | w_pt[CW];
                end
                5'd19: begin
                    r_pt[1] <= w_pt[CW-1:0];
                    r_sf    <= r_sf | w_pt[CW];
                end
                5'd20: begin
                    r_pt[2] <= w_pt[CW-1:0];
                    r_sf    <= r_sf | w_pt[CW];
                end
                default: begin
                end
            endcase
        end

        if (w_div_done) begin
            if (w_div_zero) begin
                // plane parallel to the ray: divisor one
                r_t   <= w_num_sat[CW-1:0];
                r_par <= 1'b1;
                r_sf  <= r_sf | w_num_sat[CW];
            end else begin
                r_t   <= w_div_q;
                r_par <= 1'b0;
                r_sf  <= r_sf | w_div_sat;
            end
        end

        if (i_cmd.out_load) begin
            r_out_x   <= r_pt[0];
            r_out_y   <= r_pt[1];
            r_out_z   <= r_pt[2];
            r_out_par <= r_par;
            r_out_sf  <= r_sf;
        end
    end

    assign o_point_x   = 32'(r_out_x);
    assign o_point_y   = 32'(r_out_y);
    assign o_point_z   = 32'(r_out_z);
    assign o_parallel  = r_out_par;
    assign o_saturated = r_out_sf;

endmodule

>>> design/rpi_ctrl.sv
// ----------------------------------------------------------------------------
// rpi_ctrl: sequencer of the ray/plane intersection block
// takes requests, walks the multiply schedule, waits on the quotient unit
// and hands finished points to the output register
// ----------------------------------------------------------------------------
module rpi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [2:0]        i_in_cmd,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rpi_pkg::t_dp_cmd  o_cmd,
    input  rpi_pkg::t_dp_sts  i_sts
);
    import rpi_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DIFF   = 9'b000000010,
        S_MULA   = 9'b000000100,
        S_DRAINA = 9'b000001000,
        S_DIVST  = 9'b000010000,
        S_DIVW   = 9'b000100000,
        S_MULB   = 9'b001000000,
        S_DRAINB = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_vld, n_out_vld;
    logic              w_in_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign w_in_acc    = i_in_valid && o_in_ready;

    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        o_cmd           = '0;
        o_cmd.step      = r_step;
        o_cmd.vtx_we    = w_in_acc && (i_in_cmd <= CMD_V2);
        o_cmd.org_we    = w_in_acc && (i_in_cmd == CMD_ORG);
        o_cmd.dir_we    = w_in_acc && (i_in_cmd == CMD_DIR);
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in_cmd == CMD_DIR)) n_state = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff_en = 1'b1;
                n_step        = '0;
                n_state       = S_MULA;
            end
            S_MULA: begin
                o_cmd.mul_en = 1'b1;
                if (r_step == STEP_NUM_LAST) begin
                    n_state = S_DRAINA;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DRAINA: n_state = S_DIVST;
            S_DIVST: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVW;
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    n_step  = STEP_PT_FIRST;
                    n_state = S_MULB;
                end
            end
            S_MULB: begin
                o_cmd.mul_en = 1'b1;
                if (r_step == STEP_PT_LAST) begin
                    n_state = S_DRAINB;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DRAINB: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

>>> design/ray_plane_intersection.sv
// ----------------------------------------------------------------------------
// ray_plane_intersection: ray to triangle-plane intersection, signed fixed point
// shared-origin rays against the plane of one stored triangle
// ----------------------------------------------------------------------------
// usage
//   input stream: tuser holds the request kind, tdata the x, y, z coordinate.
//     kinds 0..2 load vertex v0..v2, kind 3 loads the ray origin, kind 4 is a
//     ray direction and yields one point; kinds 5..7 are dropped quietly.
//   loads give no output.
//   once a direction is accepted, the point is computed and put into the
//   output register; the next request is taken right after that. the work
//   is done by the shared multiplier (21 products, one per cycle) and the
//   restoring divider, which makes one quotient bit of t per cycle; the
//   divider skips its bit steps when the plane is parallel or the quotient
//   does not fit in COORD_WIDTH bits.
//   output stream: tdata holds the point, tuser the parallel and saturation
//   flags. a finished point waits in the output register while the receiver
//   stalls; the next direction is computed meanwhile and holds in the
//   datapath until the output register frees up.
//   reset (synchronous, active low) clears the triangle and origin to zero,
//   empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module ray_plane_intersection #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // x_value, y_value, z_value
    input  logic [2:0]  s_axis_tuser,   // cmd
    // result requests
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // point_x, point_y, point_z
    output logic [1:0]  m_axis_tuser    // parallel_flag, saturated_flag
);
    import rpi_pkg::*;

    t_dp_cmd     w_cmd;
    t_dp_sts     w_sts;
    logic [31:0] w_px, w_py, w_pz;
    logic        w_par, w_sf;

    // sequencer: request handshake, schedule and output valid
    rpi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_cmd    (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // datapath: store, multiplier, divider and output register
    rpi_dp #(
        .COORD_WIDTH   (COORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_cmd    (s_axis_tuser),
        .i_in_x      (s_axis_tdata[31:0]),
        .i_in_y      (s_axis_tdata[63:32]),
        .i_in_z      (s_axis_tdata[95:64]),
        .o_point_x   (w_px),
        .o_point_y   (w_py),
        .o_point_z   (w_pz),
        .o_parallel  (w_par),
        .o_saturated (w_sf)
    );

    assign m_axis_tdata = {w_pz, w_py, w_px};
    assign m_axis_tuser = {w_sf, w_par};

endmodule
